[rtl/core/okc_pkg.sv]
// ----------------------------------------------------------------------------
// okc_pkg
// Shared types, field widths and operation codes of the ordered key cursor.
// ----------------------------------------------------------------------------
package okc_pkg;

  localparam int FUNC_W          = 4;
  localparam int KEY_W           = 32;
  localparam int LINK_W          = 32;
  localparam int SIZE_W          = 16;
  localparam int POS_W           = 11;
  localparam int ENTRY_W         = KEY_W + LINK_W + SIZE_W;
  localparam int IN_DATA_W       = 80;
  localparam int OUT_DATA_W      = 96;
  localparam int DEF_ENTRY_DEPTH = 1024;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 4'd0,
    FN_APPEND  = 4'd1,
    FN_REWIND  = 4'd2,
    FN_NEXT    = 4'd3,
    FN_PREV    = 4'd4,
    FN_SEEK_EQ = 4'd5,
    FN_SEEK_GT = 4'd6,
    FN_SEEK_GE = 4'd7,
    FN_SEEK_LT = 4'd8,
    FN_SEEK_LE = 4'd9
  } func_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic read;
    logic load;
  } okc_cmd_t;

  typedef struct packed {
    logic scan_start;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } okc_sts_t;

endpackage

[rtl/core/okc_ram.sv]
// ----------------------------------------------------------------------------
// okc_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module okc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/okc_ctrl.sv]
// ----------------------------------------------------------------------------
// okc_ctrl
// Sequencer: accept, execute, scan (seeks on a non-empty table), read back the entry, load the result.
// ----------------------------------------------------------------------------
module okc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  okc_pkg::okc_sts_t sts,
  output okc_pkg::okc_cmd_t cmd
);
  import okc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_FETCH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.scan_start ? ST_SCAN : ST_READ;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/okc_dpath.sv]
// ----------------------------------------------------------------------------
// okc_dpath
// Entry table, count, cursor, scan pointer and output register.
// ----------------------------------------------------------------------------
module okc_dpath #(
  parameter int ENTRY_DEPTH = okc_pkg::DEF_ENTRY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  okc_pkg::okc_cmd_t              cmd,
  output okc_pkg::okc_sts_t              sts,
  input  logic [okc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [okc_pkg::FUNC_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [okc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import okc_pkg::*;

  localparam int CNT_W  = $clog2(ENTRY_DEPTH + 1);
  localparam int ADDR_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

  func_t              req_func;
  logic [KEY_W-1:0]   req_key;
  logic [LINK_W-1:0]  req_link;
  logic [SIZE_W-1:0]  req_size;

  logic [CNT_W-1:0]   count;
  logic               cur_valid;
  logic [ADDR_W-1:0]  cur_idx;
  logic               hit;

  logic [ADDR_W-1:0]  scan_idx;
  logic [ADDR_W-1:0]  scan_end_idx;
  logic               scan_fwd;
  logic               scan_active;
  logic               chk_valid;
  logic [ADDR_W-1:0]  chk_idx;
  logic               chk_last;

  logic               is_fwd;
  logic               is_bwd;
  logic               count_nz;
  logic               not_full;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cur_inc;
  logic               key_match;
  logic               wr_en;
  logic               rd_en;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] at_entry;
  logic [KEY_W-1:0]   rd_key;
  logic [31:0]        pos_wide;
  logic [POS_W-1:0]   position;

  assign is_fwd   = (req_func == FN_SEEK_EQ) || (req_func == FN_SEEK_GT) ||
                    (req_func == FN_SEEK_GE);
  assign is_bwd   = (req_func == FN_SEEK_LT) || (req_func == FN_SEEK_LE);
  assign count_nz = (count != '0);
  assign not_full = (count < CNT_W'(ENTRY_DEPTH));
  assign cnt_m1   = count - CNT_W'(1);
  assign cur_inc  = CNT_W'(cur_idx) + CNT_W'(1);
  assign rd_key   = rd_data[KEY_W-1:0];

  always_comb begin
    case (req_func)
      FN_SEEK_EQ: key_match = (rd_key == req_key);
      FN_SEEK_GT: key_match = (rd_key > req_key);
      FN_SEEK_GE: key_match = (rd_key >= req_key);
      FN_SEEK_LT: key_match = (rd_key < req_key);
      default:    key_match = (rd_key <= req_key);
    endcase
  end

  assign wr_en = cmd.exec && (req_func == FN_APPEND) && not_full;
  assign rd_en = (cmd.scan && scan_active) || cmd.read;
  assign raddr = cmd.read ? cur_idx : scan_idx;

  okc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_DEPTH)
  ) u_table (
    .clk   (clk),
    .wr_en (wr_en),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({req_size, req_link, req_key}),
    .rd_en (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign sts.scan_start = cmd.exec && (is_fwd || is_bwd) && count_nz;
  assign sts.scan_hit   = chk_valid && key_match;
  assign sts.scan_end   = chk_valid && chk_last;
  assign sts.out_free   = !m_tvalid || m_tready;

  assign at_entry = cur_valid ? rd_data : '0;
  assign pos_wide = 32'(cur_idx);
  assign position = cur_valid ? pos_wide[POS_W-1:0] : '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      cur_valid   <= 1'b0;
      scan_active <= 1'b0;
      chk_valid   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        req_func <= func_t'(s_tuser);
        req_key  <= s_tdata[KEY_W-1:0];
        req_link <= s_tdata[KEY_W +: LINK_W];
        req_size <= s_tdata[KEY_W+LINK_W +: SIZE_W];
      end

      if (cmd.exec) begin
        hit <= 1'b0;
        case (req_func)
          FN_CLEAR: begin
            count     <= '0;
            cur_valid <= 1'b0;
          end
          FN_APPEND: begin
            if (not_full) begin
              count <= count + CNT_W'(1);
              hit   <= 1'b1;
            end
          end
          FN_REWIND: begin
            hit       <= count_nz;
            cur_valid <= count_nz;
            cur_idx   <= '0;
          end
          FN_NEXT: begin
            if (!cur_valid) begin
              if (count_nz) begin
                cur_valid <= 1'b1;
                cur_idx   <= '0;
                hit       <= 1'b1;
              end
            end else if (cur_inc < count) begin
              cur_idx <= cur_idx + ADDR_W'(1);
              hit     <= 1'b1;
            end
          end
          FN_PREV: begin
            if (cur_valid && (cur_idx != '0)) begin
              cur_idx <= cur_idx - ADDR_W'(1);
              hit     <= 1'b1;
            end
          end
          FN_SEEK_EQ, FN_SEEK_GT, FN_SEEK_GE: begin
            scan_idx     <= '0;
            scan_end_idx <= cnt_m1[ADDR_W-1:0];
            scan_fwd     <= 1'b1;
            scan_active  <= count_nz;
          end
          FN_SEEK_LT, FN_SEEK_LE: begin
            scan_idx     <= cnt_m1[ADDR_W-1:0];
            scan_end_idx <= '0;
            scan_fwd     <= 1'b0;
            scan_active  <= count_nz;
          end
          default: begin
          end
        endcase
      end

      if (cmd.scan) begin
        chk_valid <= scan_active;
        chk_idx   <= scan_idx;
        chk_last  <= (scan_idx == scan_end_idx);
        if (scan_active) begin
          if (scan_idx == scan_end_idx) begin
            scan_active <= 1'b0;
          end else begin
            scan_idx <= scan_fwd ? scan_idx + ADDR_W'(1) : scan_idx - ADDR_W'(1);
          end
        end
        if (chk_valid && key_match) begin
          hit         <= 1'b1;
          cur_valid   <= 1'b1;
          cur_idx     <= chk_idx;
          scan_active <= 1'b0;
        end
      end else begin
        chk_valid <= 1'b0;
      end

      if (cmd.load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {4'b0000, at_entry, position, hit};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/ordered_key_cursor.sv]
// ----------------------------------------------------------------------------
// ordered_key_cursor
// Cursor over an append-loaded entry table with moves and linear key seeks.
//
//   channel  dir  payload
//   s_*      in   tuser: func; tdata: key, link_key, rec_size
//   m_*      out  tdata: hit, position, at_key, at_link_key, at_size
//
// Clear, append, rewind, next and prev pass from accept through execute, read
// and load without a scan. A seek on a non-empty table also scans; the scan
// reads one stored key per cycle through the table's single read port.
// Reset empties the table and parks the cursor before the first entry.
// One item is in work at a time; a held result stalls only the load stage.
// ----------------------------------------------------------------------------
module ordered_key_cursor #(
  parameter int ENTRY_DEPTH = okc_pkg::DEF_ENTRY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // key[31:0], link_key[63:32], rec_size[79:64]
  input  logic [okc_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[3:0]
  input  logic [okc_pkg::FUNC_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hit[0], position[11:1], at_key[43:12], at_link_key[75:44], at_size[91:76]
  output logic [okc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import okc_pkg::*;

  okc_cmd_t cmd;
  okc_sts_t sts;

  okc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  okc_dpath #(
    .ENTRY_DEPTH (ENTRY_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken item");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && (sts.scan_hit || sts.scan_end)) |=> cmd.read)
    else $error("scan finished without reading back the entry");

endmodule

[tb/okc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// okc_tb_pkg
// Shadow copy of the cursor table that predicts each result and checks the
// results of the ordered key cursor field by field, in order.
// ----------------------------------------------------------------------------
package okc_tb_pkg;

  import okc_pkg::*;

  localparam int TABLE_DEPTH = DEF_ENTRY_DEPTH;

  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd10;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [SIZE_W-1:0] at_size;
    logic [LINK_W-1:0] at_link_key;
    logic [KEY_W-1:0]  at_key;
    logic [POS_W-1:0]  position;
    logic              hit;
  } cursor_view_t;

  localparam int VIEW_W = $bits(cursor_view_t);

  class cursor_shadow;
    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [LINK_W-1:0] link_mem [TABLE_DEPTH];
    logic [SIZE_W-1:0] size_mem [TABLE_DEPTH];
    int                fill;
    int                cursor;
    cursor_view_t      pending_views [$];
    int                mismatches;
    int                result_idx;

    function new();
      fill       = 0;
      cursor     = -1;
      mismatches = 0;
      result_idx = 0;
    endfunction

    function bit key_qualifies(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] stored,
                               logic [KEY_W-1:0] probe);
      case (fn)
        FN_SEEK_EQ: return stored == probe;
        FN_SEEK_GT: return stored > probe;
        FN_SEEK_GE: return stored >= probe;
        FN_SEEK_LT: return stored < probe;
        default:    return stored <= probe;
      endcase
    endfunction

    function void apply_item(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                             logic [LINK_W-1:0] link, logic [SIZE_W-1:0] size);
      cursor_view_t view;
      logic         hit;
      hit = 1'b0;
      case (fn)
        FN_CLEAR: begin
          fill   = 0;
          cursor = -1;
        end
        FN_APPEND: begin
          if (fill < TABLE_DEPTH) begin
            key_mem[fill]  = key;
            link_mem[fill] = link;
            size_mem[fill] = size;
            fill++;
            hit = 1'b1;
          end
        end
        FN_REWIND: begin
          hit    = (fill != 0);
          cursor = hit ? 0 : -1;
        end
        FN_NEXT: begin
          if (cursor + 1 < fill) begin
            cursor++;
            hit = 1'b1;
          end
        end
        FN_PREV: begin
          if (cursor >= 1) begin
            cursor--;
            hit = 1'b1;
          end
        end
        FN_SEEK_EQ, FN_SEEK_GT, FN_SEEK_GE: begin
          for (int i = 0; i < fill; i++) begin
            if (!hit && key_qualifies(fn, key_mem[i], key)) begin
              cursor = i;
              hit    = 1'b1;
            end
          end
        end
        FN_SEEK_LT, FN_SEEK_LE: begin
          for (int i = fill - 1; i >= 0; i--) begin
            if (!hit && key_qualifies(fn, key_mem[i], key)) begin
              cursor = i;
              hit    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      view.hit      = hit;
      view.position = cursor[POS_W-1:0];
      if (cursor >= 0 && cursor < fill) begin
        view.at_key      = key_mem[cursor];
        view.at_link_key = link_mem[cursor];
        view.at_size     = size_mem[cursor];
      end else begin
        view.at_key      = '0;
        view.at_link_key = '0;
        view.at_size     = '0;
      end
      pending_views.push_back(view);
    endfunction

    function void note_mismatch(string field, logic [KEY_W-1:0] want,
                                logic [KEY_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", result_idx, field, want, got);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      cursor_view_t got;
      cursor_view_t want;
      got = data[VIEW_W-1:0];
      result_idx++;
      if (pending_views.size() == 0) begin
        note_mismatch("unpaired result, position", '0, got.position);
        return;
      end
      want = pending_views.pop_front();
      if (got.hit !== want.hit)
        note_mismatch("hit", want.hit, got.hit);
      if (got.position !== want.position)
        note_mismatch("position", want.position, got.position);
      if (got.at_key !== want.at_key)
        note_mismatch("at_key", want.at_key, got.at_key);
      if (got.at_link_key !== want.at_link_key)
        note_mismatch("at_link_key", want.at_link_key, got.at_link_key);
      if (got.at_size !== want.at_size)
        note_mismatch("at_size", want.at_size, got.at_size);
      if (data[OUT_DATA_W-1:VIEW_W] !== '0)
        note_mismatch("tdata padding", '0, data[OUT_DATA_W-1:VIEW_W]);
    endfunction

    function int pending();
      return pending_views.size();
    endfunction
  endclass

endpackage

[tb/tb_ordered_key_cursor.sv]
// ----------------------------------------------------------------------------
// tb_ordered_key_cursor
// Drives clear, append, move and seek items into the ordered key cursor with
// random stalls on both streams, and checks every result against a shadow
// table: directed corner items first, then random table sessions and a
// closing stretch without stalls.
// ----------------------------------------------------------------------------
module tb_ordered_key_cursor;

  timeunit 1ns;
  timeprecision 1ps;

  import okc_pkg::*;
  import okc_tb_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int CLOSING_ITEMS = 60;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int           idle_pct = 0;
  int           cycle_count = 0;
  cursor_shadow shadow = new();

  ordered_key_cursor #(
    .ENTRY_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ordered_key_cursor NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.check_result(m_tdata);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {28'hFFFFFFF, 4'($urandom_range(0, 15))};
      3, 4:    return $urandom;
      default: return $urandom_range(0, 47);
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_seek();
    case ($urandom_range(0, 4))
      0:       return FN_SEEK_EQ;
      1:       return FN_SEEK_GT;
      2:       return FN_SEEK_GE;
      3:       return FN_SEEK_LT;
      default: return FN_SEEK_LE;
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                           input logic [LINK_W-1:0] link, input logic [SIZE_W-1:0] size);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {size, link, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.apply_item(fn, key, link, size);
  endtask

  task automatic run_random(input int count, input bit vary_idle);
    int                n;
    int                roll;
    logic [FUNC_W-1:0] fn;
    n = 0;
    while (n < count) begin
      if (vary_idle && n % 64 == 0)
        idle_pct = pick_idle();
      roll = $urandom_range(0, 99);
      if (roll < 4)
        fn = FN_CLEAR;
      else if (roll < 32)
        fn = FN_APPEND;
      else if (roll < 38)
        fn = FN_REWIND;
      else if (roll < 47)
        fn = FN_NEXT;
      else if (roll < 54)
        fn = FN_PREV;
      else if (roll < 97)
        fn = pick_seek();
      else
        fn = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      send_item(fn, pick_key(), $urandom, 16'($urandom));
      if (fn < FN_UNUSED_LO)
        n++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table
    send_item(FN_REWIND, $urandom, $urandom, 16'($urandom));
    send_item(FN_NEXT, $urandom, $urandom, 16'($urandom));
    send_item(FN_PREV, $urandom, $urandom, 16'($urandom));
    send_item(FN_SEEK_GE, '0, $urandom, 16'($urandom));
    send_item(FN_SEEK_LE, '1, $urandom, 16'($urandom));
    // unordered keys with extreme fields
    send_item(FN_APPEND, '0, '1, '1);
    send_item(FN_APPEND, '1, '0, '0);
    send_item(FN_APPEND, 32'h8000_0000, 32'h5555_5555, 16'hAAAA);
    send_item(FN_APPEND, 32'h0000_0001, 32'hAAAA_AAAA, 16'h5555);
    send_item(FN_NEXT, $urandom, $urandom, 16'($urandom));
    send_item(FN_PREV, $urandom, $urandom, 16'($urandom));
    send_item(FN_NEXT, $urandom, $urandom, 16'($urandom));
    send_item(FN_SEEK_EQ, 32'h8000_0000, $urandom, 16'($urandom));
    send_item(FN_SEEK_EQ, 32'd5, $urandom, 16'($urandom));
    send_item(FN_SEEK_GT, '1, $urandom, 16'($urandom));
    send_item(FN_SEEK_GT, '0, $urandom, 16'($urandom));
    send_item(FN_SEEK_LT, '0, $urandom, 16'($urandom));
    send_item(FN_SEEK_LT, 32'd2, $urandom, 16'($urandom));
    send_item(FN_SEEK_LE, '0, $urandom, 16'($urandom));
    send_item(FN_SEEK_LE, '1, $urandom, 16'($urandom));
    send_item(FN_NEXT, $urandom, $urandom, 16'($urandom));
    send_item(FN_UNUSED_LO, $urandom, $urandom, 16'($urandom));
    send_item(FN_UNUSED_HI, $urandom, $urandom, 16'($urandom));
    send_item(FN_REWIND, $urandom, $urandom, 16'($urandom));
    send_item(FN_CLEAR, $urandom, $urandom, 16'($urandom));

    run_random(RANDOM_ITEMS, 1'b1);

    idle_pct = 0;
    run_random(CLOSING_ITEMS, 1'b0);
    s_tvalid <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("tb_ordered_key_cursor OK");
    end else begin
      $display("tb_ordered_key_cursor NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/okc_pkg.sv
rtl/core/okc_ram.sv
rtl/core/okc_ctrl.sv
rtl/core/okc_dpath.sv
rtl/core/ordered_key_cursor.sv
tb/okc_tb_pkg.sv
tb/tb_ordered_key_cursor.sv
